>>> design/csrg_pkg.sv
// Shared types and constants for the colour-similarity region grower.
// No dependencies; every other file but csrg_stream_if imports this package.
`timescale 1ns / 1ps

package csrg_pkg;

  localparam int CfgIndexW = 8;
  localparam int CfgDataW  = 11;
  localparam int HeightW   = 11;
  localparam int ByteW     = 8;

  localparam logic [CfgIndexW-1:0] CFG_COLUMN_HEIGHT = 8'd0;
  localparam logic [CfgIndexW-1:0] CFG_HUE_TOLERANCE = 8'd1;
  localparam logic [CfgIndexW-1:0] CFG_SAT_TOLERANCE = 8'd2;
  localparam logic [CfgIndexW-1:0] CFG_VAL_TOLERANCE = 8'd3;

  localparam logic [HeightW-1:0] COLUMN_HEIGHT_RESET = 11'd480;
  localparam logic [ByteW-1:0]   HUE_TOLERANCE_RESET = 8'd2;
  localparam logic [ByteW-1:0]   SAT_TOLERANCE_RESET = 8'd13;
  localparam logic [ByteW-1:0]   VAL_TOLERANCE_RESET = 8'd26;

  typedef enum logic [1:0] {
    CLASS_BLACK = 2'd0,
    CLASS_WHITE = 2'd1,
    CLASS_RED   = 2'd2
  } pixel_class_e;

  typedef struct packed {
    logic [CfgIndexW-1:0] index;
    logic [CfgDataW-1:0]  data;
  } cfg_write_t;

  typedef struct packed {
    logic             frame_start;
    logic [ByteW-1:0] hue;
    logic [ByteW-1:0] sat;
    logic [ByteW-1:0] val;
    logic             in_largest_region;
  } pixel_t;

  typedef struct packed {
    logic         region_mask;
    pixel_class_e pixel_class;
    logic         region_flag;
  } result_t;

  // One entry of the column store: HSV bytes and the (grown) region flag.
  typedef struct packed {
    logic [ByteW-1:0] hue;
    logic [ByteW-1:0] sat;
    logic [ByteW-1:0] val;
    logic             flag;
  } column_entry_t;

  localparam int EntryW = $bits(column_entry_t);

  function automatic logic [ByteW-1:0] abs_diff(input logic [ByteW-1:0] a,
                                                input logic [ByteW-1:0] b);
    logic [ByteW-1:0] r;
    r = (a >= b) ? (a - b) : (b - a);
    return r;
  endfunction

endpackage

>>> design/csrg_stream_if.sv
// Valid/ready channel with a typed payload, used for configuration, pixels
// and results. Depends on nothing; the payload type comes from the instance.
`timescale 1ns / 1ps

interface csrg_stream_if #(
  parameter type T = logic
);
  logic valid;
  logic ready;
  T     data;

  modport source (output valid, output data, input ready);
  modport sink   (input valid, input data, output ready);
endinterface

>>> design/color_similarity_region_grow.sv
// Colour-similarity region grower. Pixels arrive column by column, top to
// bottom, each with HSV bytes and a flag from the labeller; one result leaves
// per pixel, in order. The block takes one pixel per clock while the result
// side keeps up. Stage 1 reads the previous column's entry for the same row
// from the column store; the result stage then compares, writes the entry
// back and registers the result. The column store
// holds MAX_HEIGHT entries of 25 bits and needs no clearing after reset.
// Configuration (height and the three tolerances) goes through its own
// write channel, index 0 to 3, and must only be written while the block is
// idle. A result register parts the output from the pipeline, so one pixel is
// still accepted into stage 1 while an earlier result waits to be taken.
// Depends on csrg_pkg, csrg_stream_if, csrg_column_mem and csrg_position.
`timescale 1ns / 1ps

module color_similarity_region_grow import csrg_pkg::*; #(
  parameter int MAX_HEIGHT = 1024
) (
  input  logic          clk_i,
  input  logic          rst_ni,
  csrg_stream_if.sink   cfg_i,
  csrg_stream_if.sink   pix_i,
  csrg_stream_if.source res_o
);

  localparam int RowW = $clog2(MAX_HEIGHT);

  // Configuration registers
  logic [HeightW-1:0] column_height_q;
  logic [ByteW-1:0]   hue_tol_q, sat_tol_q, val_tol_q;
  cfg_write_t         cfg_req;

  assign cfg_i.ready = 1'b1;
  assign cfg_req     = cfg_i.data;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      column_height_q <= COLUMN_HEIGHT_RESET;
      hue_tol_q       <= HUE_TOLERANCE_RESET;
      sat_tol_q       <= SAT_TOLERANCE_RESET;
      val_tol_q       <= VAL_TOLERANCE_RESET;
    end else if (cfg_i.valid) begin
      case (cfg_req.index)
        CFG_COLUMN_HEIGHT: column_height_q <= cfg_req.data;
        CFG_HUE_TOLERANCE: hue_tol_q       <= cfg_req.data[ByteW-1:0];
        CFG_SAT_TOLERANCE: sat_tol_q       <= cfg_req.data[ByteW-1:0];
        CFG_VAL_TOLERANCE: val_tol_q       <= cfg_req.data[ByteW-1:0];
        default: ;  // drop writes beyond the register list
      endcase
    end
  end

  // Handshake and pipeline control
  logic    s1_valid_q;
  logic    out_valid_q;
  logic    out_free, s1_fire, accept;
  pixel_t  pix;

  assign pix         = pix_i.data;
  assign out_free    = !out_valid_q || res_o.ready;
  assign s1_fire     = s1_valid_q && out_free;
  assign pix_i.ready = !s1_valid_q || out_free;
  assign accept      = pix_i.valid && pix_i.ready;

  // Position of the accepted pixel
  logic [RowW-1:0] row;
  logic            border;

  csrg_position #(
    .MaxHeight (MAX_HEIGHT),
    .RowW      (RowW)
  ) u_position (
    .clk_i           (clk_i),
    .rst_ni          (rst_ni),
    .advance_i       (accept),
    .frame_start_i   (pix.frame_start),
    .column_height_i (column_height_q),
    .row_o           (row),
    .border_o        (border)
  );

  // Stage 1: pixel waits here while the left neighbour is read. The write
  // of one pixel and the read of the next never hit the same non-border
  // row, so the store needs no forwarding path.
  column_entry_t   s1_pix_q;
  logic            s1_border_q;
  logic [RowW-1:0] s1_row_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      s1_valid_q <= 1'b0;
    end else if (pix_i.ready) begin
      s1_valid_q <= pix_i.valid;
    end
  end

  always_ff @(posedge clk_i) begin
    if (accept) begin
      s1_pix_q    <= '{hue: pix.hue, sat: pix.sat, val: pix.val,
                       flag: pix.in_largest_region};
      s1_border_q <= border;
      s1_row_q    <= row;
    end
  end

  // Column store
  logic [EntryW-1:0] left_raw;
  column_entry_t     left, wb_entry;

  csrg_column_mem #(
    .Depth (MAX_HEIGHT),
    .Width (EntryW),
    .AddrW (RowW)
  ) u_column_mem (
    .clk_i   (clk_i),
    .we_i    (s1_fire),
    .waddr_i (s1_row_q),
    .wdata_i (wb_entry),
    .re_i    (accept),
    .raddr_i (row),
    .rdata_o (left_raw)
  );

  assign left = column_entry_t'(left_raw);

  // Classify: border passes the flag through, a region pixel is white, a
  // close match to a flagged left neighbour joins the region in red.
  result_t res_d;
  logic    joins;

  always_comb begin
    joins = left.flag
         && (abs_diff(s1_pix_q.hue, left.hue) <= hue_tol_q)
         && (abs_diff(s1_pix_q.sat, left.sat) <= sat_tol_q)
         && (abs_diff(s1_pix_q.val, left.val) <= val_tol_q);

    res_d.region_mask = 1'b0;
    res_d.pixel_class = CLASS_BLACK;
    res_d.region_flag = s1_pix_q.flag;
    if (!s1_border_q) begin
      if (s1_pix_q.flag) begin
        res_d.region_mask = 1'b1;
        res_d.pixel_class = CLASS_WHITE;
      end else if (joins) begin
        res_d.region_mask = 1'b1;
        res_d.pixel_class = CLASS_RED;
        res_d.region_flag = 1'b1;
      end
    end

    wb_entry      = s1_pix_q;
    wb_entry.flag = res_d.region_flag;
  end

  // Result register
  result_t out_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_valid_q <= 1'b0;
    end else if (out_free) begin
      out_valid_q <= s1_valid_q;
    end
  end

  always_ff @(posedge clk_i) begin
    if (s1_fire) begin
      out_q <= res_d;
    end
  end

  assign res_o.valid = out_valid_q;
  assign res_o.data  = out_q;

endmodule

>>> design/csrg_column_mem.sv
// Column store: single-port-write, single-port-read synchronous RAM with a
// registered read. Depends on csrg_pkg for the default entry width.
`timescale 1ns / 1ps

module csrg_column_mem import csrg_pkg::*; #(
  parameter int Depth = 1024,
  parameter int Width = EntryW,
  parameter int AddrW = $clog2(Depth)
) (
  input  logic             clk_i,
  input  logic             we_i,
  input  logic [AddrW-1:0] waddr_i,
  input  logic [Width-1:0] wdata_i,
  input  logic             re_i,
  input  logic [AddrW-1:0] raddr_i,
  output logic [Width-1:0] rdata_o
);

  logic [Width-1:0] mem_q [Depth];
  logic [Width-1:0] rdata_q;

  always_ff @(posedge clk_i) begin
    if (we_i) begin
      mem_q[waddr_i] <= wdata_i;
    end
  end

  // Hold the read word while the consumer stalls.
  always_ff @(posedge clk_i) begin
    if (re_i) begin
      rdata_q <= mem_q[raddr_i];
    end
  end

  assign rdata_o = rdata_q;

endmodule

>>> design/csrg_position.sv
// Row and first-column tracker for column-major pixel order.
// Depends on csrg_pkg for the height width.
`timescale 1ns / 1ps

module csrg_position import csrg_pkg::*; #(
  parameter int MaxHeight = 1024,
  parameter int RowW      = $clog2(MaxHeight)
) (
  input  logic               clk_i,
  input  logic               rst_ni,
  input  logic               advance_i,
  input  logic               frame_start_i,
  input  logic [HeightW-1:0] column_height_i,
  output logic [RowW-1:0]    row_o,
  output logic               border_o
);

  localparam int CmpW = (RowW + 1 > HeightW) ? RowW + 1 : HeightW;

  logic [RowW-1:0] row_q, row_d;
  logic            first_q, first_d;
  logic [CmpW-1:0] height_ext, eff_height, row_plus;
  logic [RowW-1:0] pos, row_sel;
  logic            first_cur;

  always_comb begin
    height_ext = CmpW'(column_height_i);
    // Clamp the height to 1 .. MaxHeight.
    if (column_height_i == '0) begin
      eff_height = CmpW'(1);
    end else if (height_ext > CmpW'(MaxHeight)) begin
      eff_height = CmpW'(MaxHeight);
    end else begin
      eff_height = height_ext;
    end

    pos       = frame_start_i ? '0 : row_q;
    first_cur = frame_start_i | first_q;
    row_sel   = (CmpW'(pos) >= eff_height) ? '0 : pos;
    row_plus  = CmpW'(row_sel) + CmpW'(1);

    if (row_plus >= eff_height) begin
      row_d   = '0;
      first_d = 1'b0;
    end else begin
      row_d   = RowW'(row_plus);
      first_d = first_cur;
    end
  end

  assign row_o    = row_sel;
  assign border_o = first_cur | (row_sel == '0);

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      row_q   <= '0;
      first_q <= 1'b1;
    end else if (advance_i) begin
      row_q   <= row_d;
      first_q <= first_d;
    end
  end

endmodule

>>> sim/csrg_grow_checker.sv
// Checker for the colour-similarity region grower: watches the configuration,
// pixel and result channels, predicts each result and compares it.
// Depends on csrg_pkg for the channel payload types and register indexes.
`timescale 1ns / 1ps

module csrg_grow_checker import csrg_pkg::*; #(
  parameter int MAX_HEIGHT = 1024
) (
  input  logic       clk_i,
  input  logic       rst_ni,
  input  logic       cfg_valid_i,
  input  logic       cfg_ready_i,
  input  cfg_write_t cfg_data_i,
  input  logic       pix_valid_i,
  input  logic       pix_ready_i,
  input  pixel_t     pix_data_i,
  input  logic       res_valid_i,
  input  logic       res_ready_i,
  input  result_t    res_data_i,
  output int         mismatches_o,
  output int         outstanding_o
);

  column_entry_t      left_column [MAX_HEIGHT];
  logic [HeightW-1:0] column_height;
  logic [ByteW-1:0]   hue_tol;
  logic [ByteW-1:0]   sat_tol;
  logic [ByteW-1:0]   val_tol;
  int                 row_pos;
  bit                 first_column;
  result_t            expected_results [$];
  int                 mismatch_count = 0;

  function automatic int byte_gap(input logic [ByteW-1:0] a, input logic [ByteW-1:0] b);
    int d;
    d = int'(a) - int'(b);
    return (d < 0) ? -d : d;
  endfunction

  // Advance the predicted position and column store by one pixel.
  task automatic grow_pixel(input pixel_t px, output result_t r);
    int            height;
    column_entry_t left;
    logic          flag;
    if (column_height == '0) begin
      height = 1;
    end else if (int'(column_height) > MAX_HEIGHT) begin
      height = MAX_HEIGHT;
    end else begin
      height = int'(column_height);
    end
    if (px.frame_start) begin
      row_pos      = 0;
      first_column = 1'b1;
    end
    if (row_pos >= height) row_pos = 0;
    left          = left_column[row_pos];
    flag          = px.in_largest_region;
    r.region_mask = 1'b0;
    r.pixel_class = CLASS_BLACK;
    if (!first_column && row_pos != 0) begin
      if (flag) begin
        r.region_mask = 1'b1;
        r.pixel_class = CLASS_WHITE;
      end else if (left.flag &&
                   byte_gap(px.hue, left.hue) <= int'(hue_tol) &&
                   byte_gap(px.sat, left.sat) <= int'(sat_tol) &&
                   byte_gap(px.val, left.val) <= int'(val_tol)) begin
        r.region_mask = 1'b1;
        r.pixel_class = CLASS_RED;
        flag          = 1'b1;
      end
    end
    r.region_flag = flag;
    left_column[row_pos] = '{hue: px.hue, sat: px.sat, val: px.val, flag: flag};
    if (row_pos + 1 >= height) begin
      row_pos      = 0;
      first_column = 1'b0;
    end else begin
      row_pos++;
    end
  endtask

  task automatic compare_result(input result_t got);
    result_t want;
    if (expected_results.size() == 0) begin
      $error("result with no pixel waiting: mask %0d class %0d flag %0d",
             got.region_mask, got.pixel_class, got.region_flag);
      mismatch_count++;
    end else begin
      want = expected_results.pop_front();
      if (got.region_mask !== want.region_mask) begin
        $error("region_mask: expected %0d, actual %0d", want.region_mask, got.region_mask);
        mismatch_count++;
      end
      if (got.pixel_class !== want.pixel_class) begin
        $error("pixel_class: expected %0d, actual %0d", want.pixel_class, got.pixel_class);
        mismatch_count++;
      end
      if (got.region_flag !== want.region_flag) begin
        $error("region_flag: expected %0d, actual %0d", want.region_flag, got.region_flag);
        mismatch_count++;
      end
    end
  endtask

  always @(posedge clk_i or negedge rst_ni) begin : track
    result_t predicted;
    if (!rst_ni) begin
      column_height = COLUMN_HEIGHT_RESET;
      hue_tol       = HUE_TOLERANCE_RESET;
      sat_tol       = SAT_TOLERANCE_RESET;
      val_tol       = VAL_TOLERANCE_RESET;
      row_pos       = 0;
      first_column  = 1'b1;
      expected_results.delete();
    end else begin
      if (cfg_valid_i && cfg_ready_i) begin
        case (cfg_data_i.index)
          CFG_COLUMN_HEIGHT: column_height = cfg_data_i.data[HeightW-1:0];
          CFG_HUE_TOLERANCE: hue_tol = cfg_data_i.data[ByteW-1:0];
          CFG_SAT_TOLERANCE: sat_tol = cfg_data_i.data[ByteW-1:0];
          CFG_VAL_TOLERANCE: val_tol = cfg_data_i.data[ByteW-1:0];
          default: ;
        endcase
      end
      if (pix_valid_i && pix_ready_i) begin
        grow_pixel(pix_data_i, predicted);
        expected_results.push_back(predicted);
      end
      if (res_valid_i && res_ready_i) compare_result(res_data_i);
    end
    mismatches_o  <= mismatch_count;
    outstanding_o <= expected_results.size();
  end

endmodule

>>> sim/testbench.sv
// Top of the region grower testbench: clock, reset, pixel and configuration
// stimulus, result back-pressure and the verdict.
// Depends on csrg_pkg, csrg_stream_if, the block and csrg_grow_checker.
`timescale 1ns / 1ps

module testbench;
  import csrg_pkg::*;

  localparam int MaxHeight      = 1024;
  localparam int LongHoldCycles = 300;
  localparam int DrainLimit     = 20000;
  localparam int PhaseItems     = 9;
  localparam int RandomPhases   = 12;

  logic clk_i  = 1'b0;
  logic rst_ni = 1'b0;

  csrg_stream_if #(.T(cfg_write_t)) cfg_if ();
  csrg_stream_if #(.T(pixel_t))     pix_if ();
  csrg_stream_if #(.T(result_t))    res_if ();

  int mismatch_total;
  int outstanding;

  // Idle percentages for each side and the one-off request for a long hold;
  // all written with nonblocking assignments from the stimulus process.
  int src_idle_pct;
  int sink_idle_pct;
  bit long_hold_armed = 1'b0;

  // Stimulus-side copy of the previous column, used only to shape new pixels
  // so that many of them land near their left neighbour.
  bit [7:0] left_hue [MaxHeight];
  bit [7:0] left_sat [MaxHeight];
  bit [7:0] left_val [MaxHeight];
  int       gen_row    = 0;
  int       gen_height = 480;
  int       gen_tol_hue;
  int       gen_tol_sat;
  int       gen_tol_val;

  always #5 clk_i = ~clk_i;

  color_similarity_region_grow #(
    .MAX_HEIGHT (MaxHeight)
  ) i_dut (
    .clk_i  (clk_i),
    .rst_ni (rst_ni),
    .cfg_i  (cfg_if),
    .pix_i  (pix_if),
    .res_o  (res_if)
  );

  csrg_grow_checker #(
    .MAX_HEIGHT (MaxHeight)
  ) i_checker (
    .clk_i         (clk_i),
    .rst_ni        (rst_ni),
    .cfg_valid_i   (cfg_if.valid),
    .cfg_ready_i   (cfg_if.ready),
    .cfg_data_i    (cfg_if.data),
    .pix_valid_i   (pix_if.valid),
    .pix_ready_i   (pix_if.ready),
    .pix_data_i    (pix_if.data),
    .res_valid_i   (res_if.valid),
    .res_ready_i   (res_if.ready),
    .res_data_i    (res_if.data),
    .mismatches_o  (mismatch_total),
    .outstanding_o (outstanding)
  );

  // Result side: drop ready at random per the current idle percentage, and
  // once, when asked, hold it low for a long stretch so the pipeline fills
  // and the block has to push back on its pixel input.
  initial begin : result_sink
    int hold_left;
    bit hold_done;
    hold_left = 0;
    hold_done = 1'b0;
    res_if.ready <= 1'b0;
    forever begin
      @(posedge clk_i);
      if (long_hold_armed && !hold_done) begin
        hold_done = 1'b1;
        hold_left = LongHoldCycles;
      end
      if (hold_left > 0) begin
        hold_left--;
        res_if.ready <= 1'b0;
      end else begin
        res_if.ready <= ($urandom_range(99) >= sink_idle_pct);
      end
    end
  end

  function automatic pixel_t pixel_of(input bit fs, input int h, input int s, input int v,
                                      input bit f);
    pixel_t p;
    p.frame_start       = fs;
    p.hue               = ByteW'(h);
    p.sat               = ByteW'(s);
    p.val               = ByteW'(v);
    p.in_largest_region = f;
    return p;
  endfunction

  // Pick a byte within a little more than the tolerance of the base value.
  function automatic bit [7:0] near_byte(input bit [7:0] base, input int tol);
    int span;
    int v;
    span = (tol + 2 > 255) ? 255 : tol + 2;
    if ($urandom_range(1) == 1) begin
      v = int'(base) + int'($urandom_range(span));
    end else begin
      v = int'(base) - int'($urandom_range(span));
    end
    if (v < 0) v = 0;
    if (v > 255) v = 255;
    return v[7:0];
  endfunction

  task automatic next_pixel(input bit fs, output pixel_t p);
    if (fs) gen_row = 0;
    if (gen_row >= gen_height) gen_row = 0;
    p.frame_start = fs;
    if ($urandom_range(99) < 65) begin
      p.hue = near_byte(left_hue[gen_row], gen_tol_hue);
      p.sat = near_byte(left_sat[gen_row], gen_tol_sat);
      p.val = near_byte(left_val[gen_row], gen_tol_val);
    end else begin
      p.hue = ByteW'($urandom_range(255));
      p.sat = ByteW'($urandom_range(255));
      p.val = ByteW'($urandom_range(255));
    end
    p.in_largest_region = ($urandom_range(99) < 30);
    left_hue[gen_row] = p.hue;
    left_sat[gen_row] = p.sat;
    left_val[gen_row] = p.val;
    gen_row = (gen_row + 1 >= gen_height) ? 0 : gen_row + 1;
  endtask

  // Offer one pixel after a random idle gap and hold it until accepted.
  task automatic offer_pixel(input pixel_t p);
    while ($urandom_range(99) < src_idle_pct) begin
      pix_if.valid <= 1'b0;
      @(posedge clk_i);
    end
    pix_if.valid <= 1'b1;
    pix_if.data  <= p;
    do @(posedge clk_i); while (!pix_if.ready);
  endtask

  // Drop valid and wait until every expected result has been taken, then let
  // the pipeline settle before anything is reconfigured.
  task automatic wait_idle();
    int waited;
    pix_if.valid <= 1'b0;
    waited = 0;
    do begin
      @(posedge clk_i);
      waited++;
    end while (outstanding != 0 && waited < DrainLimit);
    repeat (4) @(posedge clk_i);
  endtask

  // Write all four registers back to back; only called while idle.
  task automatic program_block(input int height, input int tol_h, input int tol_s,
                               input int tol_v);
    logic [CfgIndexW-1:0] reg_index [4];
    int                   reg_value [4];
    cfg_write_t           w;
    reg_index = '{CFG_COLUMN_HEIGHT, CFG_HUE_TOLERANCE, CFG_SAT_TOLERANCE,
                  CFG_VAL_TOLERANCE};
    reg_value = '{height, tol_h, tol_s, tol_v};
    for (int i = 0; i < 4; i++) begin
      w.index = reg_index[i];
      w.data  = CfgDataW'(reg_value[i]);
      cfg_if.valid <= 1'b1;
      cfg_if.data  <= w;
      do @(posedge clk_i); while (!cfg_if.ready);
    end
    cfg_if.valid <= 1'b0;
    gen_height  = (height < 1) ? 1 : (height > MaxHeight) ? MaxHeight : height;
    gen_tol_hue = tol_h;
    gen_tol_sat = tol_s;
    gen_tol_val = tol_v;
  endtask

  // One configuration, then a frame of pixels; noise_pct sets how often a
  // stray frame start breaks the frame part-way through.
  task automatic run_phase(input int height, input int tol_h, input int tol_s, input int tol_v,
                           input int count, input int noise_pct);
    pixel_t p;
    bit     fs;
    program_block(height, tol_h, tol_s, tol_v);
    for (int i = 0; i < count; i++) begin
      fs = (i == 0) || ($urandom_range(99) < noise_pct);
      next_pixel(fs, p);
      offer_pixel(p);
    end
    wait_idle();
  endtask

  initial begin : stimulus
    int height;
    int th;
    int ts;
    int tv;
    cfg_if.valid  <= 1'b0;
    cfg_if.data   <= '0;
    pix_if.valid  <= 1'b0;
    pix_if.data   <= '0;
    src_idle_pct  <= 8;
    sink_idle_pct <= 85;
    repeat (6) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);

    // No frame start yet: position runs on from reset, first column, row 0.
    offer_pixel(pixel_of(1'b0, 255, 0, 255, 1'b1));
    offer_pixel(pixel_of(1'b0, 0, 255, 0, 1'b0));
    offer_pixel(pixel_of(1'b0, 128, 128, 128, 1'b1));
    wait_idle();

    // Two-row frame at the reset tolerances: row 0 is border, row 1 compares
    // against the same row of the previous column.
    program_block(2, HUE_TOLERANCE_RESET, SAT_TOLERANCE_RESET, VAL_TOLERANCE_RESET);
    offer_pixel(pixel_of(1'b1, 0, 0, 0, 1'b1));         // frame start, flag passes
    offer_pixel(pixel_of(1'b0, 255, 255, 255, 1'b1));   // first column stays black
    offer_pixel(pixel_of(1'b0, 9, 9, 9, 1'b0));
    offer_pixel(pixel_of(1'b0, 255, 255, 255, 1'b1));   // labelled pixel: white
    offer_pixel(pixel_of(1'b0, 9, 9, 9, 1'b1));         // top row with flag: black
    offer_pixel(pixel_of(1'b0, 253, 242, 229, 1'b0));   // every gap at its limit: red
    offer_pixel(pixel_of(1'b0, 0, 0, 0, 1'b0));
    offer_pixel(pixel_of(1'b0, 250, 242, 229, 1'b0));   // hue one over: black
    offer_pixel(pixel_of(1'b0, 0, 0, 0, 1'b0));
    offer_pixel(pixel_of(1'b0, 250, 242, 229, 1'b0));   // same bytes, left flag clear
    offer_pixel(pixel_of(1'b0, 0, 0, 0, 1'b0));
    offer_pixel(pixel_of(1'b0, 100, 100, 100, 1'b1));
    offer_pixel(pixel_of(1'b0, 0, 0, 0, 1'b0));
    offer_pixel(pixel_of(1'b0, 100, 114, 100, 1'b0));   // saturation one over
    offer_pixel(pixel_of(1'b0, 0, 0, 0, 1'b0));
    offer_pixel(pixel_of(1'b0, 100, 100, 100, 1'b1));
    offer_pixel(pixel_of(1'b0, 0, 0, 0, 1'b0));
    offer_pixel(pixel_of(1'b0, 100, 100, 127, 1'b0));   // value one over
    offer_pixel(pixel_of(1'b0, 0, 0, 0, 1'b0));
    offer_pixel(pixel_of(1'b0, 2, 13, 26, 1'b1));
    offer_pixel(pixel_of(1'b0, 0, 0, 0, 1'b0));
    offer_pixel(pixel_of(1'b0, 0, 0, 0, 1'b0));         // gaps downward at limit: red
    wait_idle();

    // Random frames: receiver sparse first, then sender sparse, then flat out.
    for (int phase = 0; phase < RandomPhases; phase++) begin
      if (phase == RandomPhases / 3) begin
        src_idle_pct  <= 85;
        sink_idle_pct <= 8;
      end else if (phase == 2 * RandomPhases / 3) begin
        src_idle_pct  <= 0;
        sink_idle_pct <= 0;
      end
      case (phase)
        2:       height = 0;          // acts as a height of one
        5:       height = 1;
        9:       height = 3;
        default: height = $urandom_range(2, 4);
      endcase
      case (phase % 4)
        0: begin
          th = 0;
          ts = 0;
          tv = 0;
        end
        1: begin
          th = 255;
          ts = 255;
          tv = 255;
        end
        default: begin
          th = $urandom_range(40);
          ts = $urandom_range(40);
          tv = $urandom_range(40);
        end
      endcase
      run_phase(height, th, ts, tv, PhaseItems, 2);
    end

    // Height above the store clamps to its size; cross one full column so
    // the second column reads back what the first wrote. Hold the receiver
    // off at the start while pixels keep coming.
    long_hold_armed <= 1'b1;
    run_phase(2047, 255, 255, 255, MaxHeight + 8, 0);

    if (mismatch_total == 0 && outstanding == 0) begin
      $display("TEST PASSED");
    end else begin
      $display("TEST FAILED");
    end
    $finish;
  end

  initial begin : watchdog
    #3_000_000;
    $display("TEST FAILED");
    $finish;
  end

endmodule
